@@ src/scvp_pkg.sv @@
// Shared types, constants and helper functions for the sky component visibility predictor.
// Depends on nothing; scvp_core, scvp_apply and the top level import it.
package scvp_pkg;

  // Pipeline geometry
  localparam int CORDIC_STAGES = 20;
  localparam int DIV_STEPS     = 5;
  localparam int CORE_STAGES   = DIV_STEPS + CORDIC_STAGES;
  localparam int FRONT_STAGES  = 4;
  localparam int APPLY_STAGES  = 4;
  localparam int PIPE_DEPTH    = FRONT_STAGES + CORE_STAGES + APPLY_STAGES + 1;
  localparam int FILL_W        = $clog2(PIPE_DEPTH + 1);

  // Register map
  localparam int REG_ADDR_W = 5;
  localparam logic [2:0] REG_DIR_L       = 3'd0;
  localparam logic [2:0] REG_DIR_M       = 3'd1;
  localparam logic [2:0] REG_N_MINUS_ONE = 3'd2;
  localparam logic [2:0] REG_GAUSS       = 3'd3;
  localparam logic [2:0] REG_SHAPE_A     = 3'd4;
  localparam logic [2:0] REG_SHAPE_B     = 3'd5;
  localparam logic [2:0] REG_SHAPE_C     = 3'd6;
  localparam logic [2:0] REG_SHAPE_D     = 3'd7;

  // Arithmetic constants
  localparam logic signed [33:0] CIRC_INV_GAIN = 34'sd652032874;
  localparam logic signed [35:0] HYP_INV_GAIN  = 36'sd1296540104;
  localparam logic [31:0]        LN2_Q32       = 32'd2977044472;
  localparam logic [44:0]        TAPER_OVER    = 45'd92288378632;  // 31 * ln2 in Q.32
  localparam logic signed [33:0] QUARTER_TURN  = 34'sd1073741824;
  localparam logic signed [33:0] HALF_TURN     = 34'sd2147483648;
  localparam logic signed [48:0] TAPER_LIMIT   = 49'sd2097152;
  localparam logic signed [31:0] UNITY_GAIN    = 32'sd1073741824;

  // Arctangent in turns, Q0.32
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // Hyperbolic arctangent, Q.32
  localparam logic [31:0] ATANH_Q32 [33] = '{
    32'd0, 32'd2359251925, 32'd1096989674, 32'd539693625, 32'd268785803,
    32'd134261444, 32'd67114326, 32'd33555115, 32'd16777301, 32'd8388619,
    32'd4194305, 32'd2097152, 32'd1048576, 32'd524288, 32'd262144,
    32'd131072, 32'd65536, 32'd32768, 32'd16384, 32'd8192, 32'd4096,
    32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128, 32'd64, 32'd32, 32'd16,
    32'd8, 32'd4, 32'd2, 32'd1
  };

  typedef logic [7:0][23:0] pol_t;

  typedef struct packed {
    logic signed [33:0] cz;
    logic               neg;
    logic [44:0]        rem;
    logic               zero;
    logic               gauss;
    pol_t               pol;
  } core_in_t;

  typedef struct packed {
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic               neg;
    logic signed [35:0] hx;
    logic signed [35:0] hy;
    logic [4:0]         k;
    logic               zero;
    logic               gauss;
    pol_t               pol;
  } core_out_t;

  typedef struct packed {
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [33:0] cz;
    logic               neg;
    logic signed [35:0] hx;
    logic signed [35:0] hy;
    logic signed [34:0] hz;
    logic [44:0]        rem;
    logic [4:0]         k;
    logic               zero;
    logic               gauss;
    pol_t               pol;
  } core_st_t;

  // Shift index of hyperbolic step n (steps 4 and 13 are repeated)
  function automatic int hyp_idx(input int step);
    int   idx;
    logic rep;
    idx = 1;
    rep = 1'b0;
    for (int i = 0; i < step; i++) begin
      if ((idx == 4 || idx == 13) && !rep) begin
        rep = 1'b1;
      end else begin
        idx++;
        rep = 1'b0;
      end
    end
    return idx;
  endfunction

  // Clamp to the 24-bit output range
  function automatic logic [23:0] sat24(input logic signed [31:0] v);
    logic [23:0] res;
    if (v > 32'sd8388607) begin
      res = 24'h7FFFFF;
    end else if (v < -32'sd8388608) begin
      res = 24'h800000;
    end else begin
      res = v[23:0];
    end
    return res;
  endfunction

endpackage

@@ src/scvp_in_if.sv @@
// Input channel of the visibility predictor: one baseline sample and its brightnesses.
// Stand-alone interface, no dependencies.
interface scvp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_u;
  logic signed [31:0] coord_v;
  logic signed [31:0] coord_w;
  logic signed [23:0] pol_xx_re;
  logic signed [23:0] pol_xx_im;
  logic signed [23:0] pol_xy_re;
  logic signed [23:0] pol_xy_im;
  logic signed [23:0] pol_yx_re;
  logic signed [23:0] pol_yx_im;
  logic signed [23:0] pol_yy_re;
  logic signed [23:0] pol_yy_im;

  modport source (
    output valid, coord_u, coord_v, coord_w, pol_xx_re, pol_xx_im, pol_xy_re,
    pol_xy_im, pol_yx_re, pol_yx_im, pol_yy_re, pol_yy_im,
    input  ready
  );
  modport sink (
    input  valid, coord_u, coord_v, coord_w, pol_xx_re, pol_xx_im, pol_xy_re,
    pol_xy_im, pol_yx_re, pol_yx_im, pol_yy_re, pol_yy_im,
    output ready
  );
endinterface

@@ src/scvp_out_if.sv @@
// Result channel of the visibility predictor: four complex visibilities.
// Stand-alone interface, no dependencies.
interface scvp_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] vis_xx_re;
  logic signed [23:0] vis_xx_im;
  logic signed [23:0] vis_xy_re;
  logic signed [23:0] vis_xy_im;
  logic signed [23:0] vis_yx_re;
  logic signed [23:0] vis_yx_im;
  logic signed [23:0] vis_yy_re;
  logic signed [23:0] vis_yy_im;

  modport source (
    output valid, vis_xx_re, vis_xx_im, vis_xy_re, vis_xy_im, vis_yx_re,
    vis_yx_im, vis_yy_re, vis_yy_im,
    input  ready
  );
  modport sink (
    input  valid, vis_xx_re, vis_xx_im, vis_xy_re, vis_xy_im, vis_yx_re,
    vis_yx_im, vis_yy_re, vis_yy_im,
    output ready
  );
endinterface

@@ src/scvp_core.sv @@
// Taper exponent division, circular CORDIC (sine/cosine) and hyperbolic CORDIC
// (exp) as one register stage per step. Depends on scvp_pkg.
module scvp_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  scvp_pkg::core_in_t   in_data,
  output logic                 out_valid,
  output scvp_pkg::core_out_t  out_data
);
  import scvp_pkg::*;

  core_st_t                 head;
  core_st_t                 stg_r [CORE_STAGES];
  logic [CORE_STAGES-1:0]   vld_r;

  // Seed both rotators from the input transfer
  always_comb begin
    head       = '0;
    head.cx    = CIRC_INV_GAIN;
    head.cz    = in_data.cz;
    head.neg   = in_data.neg;
    head.hx    = HYP_INV_GAIN;
    head.rem   = in_data.rem;
    head.zero  = in_data.zero;
    head.gauss = in_data.gauss;
    head.pol   = in_data.pol;
  end

  for (genvar s = 0; s < CORE_STAGES; s++) begin : g_stage
    core_st_t prv;
    core_st_t nxt;

    if (s == 0) begin : g_first
      assign prv = head;
    end else begin : g_chain
      assign prv = stg_r[s-1];
    end

    if (s < DIV_STEPS) begin : g_div
      // One quotient bit of t / ln2 per stage, most significant first
      localparam int B = DIV_STEPS - 1 - s;
      localparam logic [44:0] DVS = 45'(LN2_Q32) << B;
      always_comb begin
        nxt = prv;
        if (prv.rem >= DVS) begin
          nxt.rem  = prv.rem - DVS;
          nxt.k[B] = 1'b1;
        end
        if (s == DIV_STEPS - 1) begin
          nxt.hz = -$signed({2'b00, nxt.rem[32:0]});
        end
      end
    end else begin : g_rot
      localparam int I  = s - DIV_STEPS;
      localparam int HI = hyp_idx(I);
      localparam logic signed [33:0] AT = $signed({2'b00, ATAN_TURNS[I%32]});
      localparam logic signed [34:0] AH = $signed({3'b000, ATANH_Q32[HI]});
      always_comb begin
        nxt = prv;
        // Circular rotation towards zero residual angle
        if (!prv.cz[33]) begin
          nxt.cx = prv.cx - ($signed(prv.cy) >>> (I % 32));
          nxt.cy = prv.cy + ($signed(prv.cx) >>> (I % 32));
          nxt.cz = prv.cz - AT;
        end else begin
          nxt.cx = prv.cx + ($signed(prv.cy) >>> (I % 32));
          nxt.cy = prv.cy - ($signed(prv.cx) >>> (I % 32));
          nxt.cz = prv.cz + AT;
        end
        // Hyperbolic rotation for exp of the residual
        if (!prv.hz[34]) begin
          nxt.hx = prv.hx + ($signed(prv.hy) >>> HI);
          nxt.hy = prv.hy + ($signed(prv.hx) >>> HI);
          nxt.hz = prv.hz - AH;
        end else begin
          nxt.hx = prv.hx - ($signed(prv.hy) >>> HI);
          nxt.hy = prv.hy - ($signed(prv.hx) >>> HI);
          nxt.hz = prv.hz + AH;
        end
      end
    end

    // Advance the stage when the pipeline moves
    always_ff @(posedge clk) begin
      if (adv) begin
        stg_r[s] <= nxt;
      end
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[CORE_STAGES-2:0], in_valid};
    end
  end

  assign out_valid      = vld_r[CORE_STAGES-1];
  assign out_data.cx    = stg_r[CORE_STAGES-1].cx;
  assign out_data.cy    = stg_r[CORE_STAGES-1].cy;
  assign out_data.neg   = stg_r[CORE_STAGES-1].neg;
  assign out_data.hx    = stg_r[CORE_STAGES-1].hx;
  assign out_data.hy    = stg_r[CORE_STAGES-1].hy;
  assign out_data.k     = stg_r[CORE_STAGES-1].k;
  assign out_data.zero  = stg_r[CORE_STAGES-1].zero;
  assign out_data.gauss = stg_r[CORE_STAGES-1].gauss;
  assign out_data.pol   = stg_r[CORE_STAGES-1].pol;

endmodule

@@ src/scvp_apply.sv @@
// Forms the taper, rotates the four brightnesses and applies the taper,
// four register stages. Depends on scvp_pkg.
module scvp_apply (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  scvp_pkg::core_out_t  in_data,
  output logic                 out_valid,
  output logic [7:0][31:0]     out_val
);
  import scvp_pkg::*;

  logic [APPLY_STAGES-1:0] vld_r;

  // Stage one: taper gain and signed sine/cosine
  logic signed [31:0] g_r, g_nxt, g2_r;
  logic signed [34:0] c_r, c_nxt, s_r, s_nxt;
  pol_t               pol_r;

  // Stage two: the sixteen rotation products
  logic signed [58:0] m_rc_r [4];
  logic signed [58:0] m_is_r [4];
  logic signed [58:0] m_rs_r [4];
  logic signed [58:0] m_ic_r [4];
  logic signed [31:0] g1_r;

  // Stage three: rotated values; stage four: tapered products
  logic signed [29:0] rot_r [8];
  logic signed [61:0] tap_r [8];

  always_comb begin
    logic signed [36:0] hsum;
    logic signed [36:0] gsh;
    hsum = 37'($signed(in_data.hx)) + 37'($signed(in_data.hy));
    gsh  = hsum >>> in_data.k;
    if (!in_data.gauss) begin
      g_nxt = UNITY_GAIN;
    end else if (in_data.zero) begin
      g_nxt = '0;
    end else begin
      g_nxt = gsh[31:0];
    end
    if (in_data.neg) begin
      c_nxt = -35'($signed(in_data.cx));
      s_nxt = -35'($signed(in_data.cy));
    end else begin
      c_nxt = 35'($signed(in_data.cx));
      s_nxt = 35'($signed(in_data.cy));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_r   <= g_nxt;
      c_r   <= c_nxt;
      s_r   <= s_nxt;
      pol_r <= in_data.pol;
      g1_r  <= g_r;
      g2_r  <= g1_r;
      for (int p = 0; p < 4; p++) begin
        m_rc_r[p] <= $signed(pol_r[2*p])   * c_r;
        m_is_r[p] <= $signed(pol_r[2*p+1]) * s_r;
        m_rs_r[p] <= $signed(pol_r[2*p])   * s_r;
        m_ic_r[p] <= $signed(pol_r[2*p+1]) * c_r;
      end
      for (int p = 0; p < 4; p++) begin
        rot_r[2*p]   <= 30'((60'(m_rc_r[p]) - 60'(m_is_r[p])) >>> 30);
        rot_r[2*p+1] <= 30'((60'(m_rs_r[p]) + 60'(m_ic_r[p])) >>> 30);
      end
      for (int q = 0; q < 8; q++) begin
        tap_r[q] <= rot_r[q] * g2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[APPLY_STAGES-2:0], in_valid};
    end
  end

  // Drop the taper fraction bits
  always_comb begin
    for (int q = 0; q < 8; q++) begin
      out_val[q] = 32'(tap_r[q] >>> 30);
    end
  end

  assign out_valid = vld_r[APPLY_STAGES-1];

endmodule

@@ src/sky_component_visibility_predict.sv @@
// Visibility predictor for one point or Gaussian sky component, with APB setup.
// Depends on scvp_pkg, scvp_in_if, scvp_out_if, scvp_core and scvp_apply.
//
// One baseline sample enters per clock while the pipeline advances; on its way
// out, four stages form the phase and the Gaussian exponent, five stages divide
// the exponent by ln 2, twenty stages run the circular and hyperbolic CORDIC
// side by side, four stages rotate and taper, and the output register holds
// the result. The whole pipeline moves as one; while a result waits in the
// output register and is not taken, nothing advances and no sample is taken.
// Write the registers only while no sample is in flight.
module sky_component_visibility_predict (
  input  logic                              clk,
  input  logic                              rst_n,
  scvp_in_if.sink                           in_bus,
  scvp_out_if.source                        out_bus,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [scvp_pkg::REG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import scvp_pkg::*;

  // Configuration registers
  logic signed [31:0] dir_l_r, dir_m_r, shape_a_r, shape_b_r, shape_c_r, shape_d_r;
  logic signed [30:0] nm1_r;
  logic               gauss_r;
  logic               cfg_wr;

  logic adv;
  logic in_acc, out_acc;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Take a register write on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_l_r   <= '0;
      dir_m_r   <= '0;
      nm1_r     <= '0;
      gauss_r   <= 1'b0;
      shape_a_r <= '0;
      shape_b_r <= '0;
      shape_c_r <= '0;
      shape_d_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_DIR_L:       dir_l_r   <= pwdata;
        REG_DIR_M:       dir_m_r   <= pwdata;
        REG_N_MINUS_ONE: nm1_r     <= pwdata[30:0];
        REG_GAUSS:       gauss_r   <= pwdata[0];
        REG_SHAPE_A:     shape_a_r <= pwdata;
        REG_SHAPE_B:     shape_b_r <= pwdata;
        REG_SHAPE_C:     shape_c_r <= pwdata;
        REG_SHAPE_D:     shape_d_r <= pwdata;
        default:         ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_DIR_L:       prdata = dir_l_r;
      REG_DIR_M:       prdata = dir_m_r;
      REG_N_MINUS_ONE: prdata = {1'b0, nm1_r};
      REG_GAUSS:       prdata = {31'b0, gauss_r};
      REG_SHAPE_A:     prdata = shape_a_r;
      REG_SHAPE_B:     prdata = shape_b_r;
      REG_SHAPE_C:     prdata = shape_c_r;
      REG_SHAPE_D:     prdata = shape_d_r;
      default:         prdata = '0;
    endcase
  end

  // Pipeline moves whenever the output register is free or being drained
  logic out_valid_r;
  assign adv          = !out_valid_r || out_bus.ready;
  assign in_bus.ready = adv;
  assign in_acc       = in_bus.valid && adv;
  assign out_acc      = out_valid_r && out_bus.ready;

  // Front stage one: all coordinate products
  logic               f1_v_r;
  logic [37:0]        pul_r, pvm_r, pwn_r;
  logic signed [63:0] pua_r, pvb_r, puc_r, pvd_r;
  logic               f1_gauss_r;
  pol_t               f1_pol_r;
  logic signed [63:0] pul_nxt, pvm_nxt, pwn_nxt;
  logic signed [63:0] pua_nxt, pvb_nxt, puc_nxt, pvd_nxt;

  always_comb begin
    pul_nxt = in_bus.coord_u * dir_l_r;
    pvm_nxt = in_bus.coord_v * dir_m_r;
    pwn_nxt = in_bus.coord_w * nm1_r;
    pua_nxt = in_bus.coord_u * shape_a_r;
    pvb_nxt = in_bus.coord_v * shape_b_r;
    puc_nxt = in_bus.coord_u * shape_c_r;
    pvd_nxt = in_bus.coord_v * shape_d_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pul_r      <= pul_nxt[37:0];
      pvm_r      <= pvm_nxt[37:0];
      pwn_r      <= pwn_nxt[37:0];
      pua_r      <= pua_nxt;
      pvb_r      <= pvb_nxt;
      puc_r      <= puc_nxt;
      pvd_r      <= pvd_nxt;
      f1_gauss_r <= gauss_r;
      f1_pol_r   <= {in_bus.pol_yy_im, in_bus.pol_yy_re, in_bus.pol_yx_im,
                     in_bus.pol_yx_re, in_bus.pol_xy_im, in_bus.pol_xy_re,
                     in_bus.pol_xx_im, in_bus.pol_xx_re};
    end
  end

  // Front stage two: phase angle and the transformed coordinates
  logic               f2_v_r;
  logic [31:0]        angle_r;
  logic signed [21:0] up_r, vp_r;
  logic               f2_big_r, f2_gauss_r;
  pol_t               f2_pol_r;
  logic [37:0]        acc_nxt;
  logic signed [48:0] up_nxt, vp_nxt;

  always_comb begin
    acc_nxt = pul_r + pvm_r + pwn_r;
    up_nxt  = 49'(pua_r >>> 16) + 49'(pvb_r >>> 16);
    vp_nxt  = 49'(puc_r >>> 16) + 49'(pvd_r >>> 16);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      angle_r    <= acc_nxt[37:6];
      up_r       <= up_nxt[21:0];
      vp_r       <= vp_nxt[21:0];
      f2_big_r   <= (up_nxt >= TAPER_LIMIT) || (up_nxt <= -TAPER_LIMIT) ||
                    (vp_nxt >= TAPER_LIMIT) || (vp_nxt <= -TAPER_LIMIT);
      f2_gauss_r <= f1_gauss_r;
      f2_pol_r   <= f1_pol_r;
    end
  end

  // Front stage three: fold the angle into a half turn, square u' and v'
  logic               f3_v_r;
  logic signed [33:0] z_r, z_nxt;
  logic               neg_r, neg_nxt;
  logic signed [43:0] squ_r, sqv_r;
  logic               f3_big_r, f3_gauss_r;
  pol_t               f3_pol_r;

  always_comb begin
    z_nxt   = 34'($signed(angle_r));
    neg_nxt = 1'b0;
    if (z_nxt > QUARTER_TURN) begin
      z_nxt   = z_nxt - HALF_TURN;
      neg_nxt = 1'b1;
    end else if (z_nxt < -QUARTER_TURN) begin
      z_nxt   = z_nxt + HALF_TURN;
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z_r        <= z_nxt;
      neg_r      <= neg_nxt;
      squ_r      <= up_r * up_r;
      sqv_r      <= vp_r * vp_r;
      f3_big_r   <= f2_big_r;
      f3_gauss_r <= f2_gauss_r;
      f3_pol_r   <= f2_pol_r;
    end
  end

  // Front stage four: exponent sum and underflow check
  logic        f4_v_r;
  core_in_t    core_in_r;
  logic [44:0] t_nxt;

  assign t_nxt = 45'(squ_r) + 45'(sqv_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      core_in_r.cz    <= z_r;
      core_in_r.neg   <= neg_r;
      core_in_r.rem   <= t_nxt;
      core_in_r.zero  <= f3_big_r || (t_nxt >= TAPER_OVER);
      core_in_r.gauss <= f3_gauss_r;
      core_in_r.pol   <= f3_pol_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
      f4_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r <= in_bus.valid;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
      f4_v_r <= f3_v_r;
    end
  end

  // CORDIC core and rotation/taper back end
  logic             core_v;
  core_out_t        core_out;
  logic             app_v;
  logic [7:0][31:0] app_val;

  scvp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (f4_v_r),
    .in_data   (core_in_r),
    .out_valid (core_v),
    .out_data  (core_out)
  );

  scvp_apply u_apply (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (core_v),
    .in_data   (core_out),
    .out_valid (app_v),
    .out_val   (app_val)
  );

  // Output register with saturation
  logic [7:0][23:0] vis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= app_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int q = 0; q < 8; q++) begin
        vis_r[q] <= sat24(app_val[q]);
      end
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.vis_xx_re = vis_r[0];
  assign out_bus.vis_xx_im = vis_r[1];
  assign out_bus.vis_xy_re = vis_r[2];
  assign out_bus.vis_xy_im = vis_r[3];
  assign out_bus.vis_yx_re = vis_r[4];
  assign out_bus.vis_yx_im = vis_r[5];
  assign out_bus.vis_yy_re = vis_r[6];
  assign out_bus.vis_yy_im = vis_r[7];

  // Count samples in flight, for the checks below
  logic [FILL_W-1:0] fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

  a_out_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (fill_r != '0))
    else $error("result presented with no sample in flight");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(PIPE_DEPTH))
    else $error("more samples in flight than pipeline stages");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |-> !in_bus.ready)
    else $error("sample taken while the output is stalled");

  a_reset_clears_out: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r)
    else $error("result valid straight after reset");

endmodule
